FILE: design/cbiq_pkg.sv
// ----------------------------------------------------------------------------
// cbiq_pkg
// Types and constants shared by the cascaded biquad IIR core: register
// indexes, sequencer states, MAC step codes and the per-section delay word.
// ----------------------------------------------------------------------------
package cbiq_pkg;

	localparam int SAMPLE_W = 16;
	localparam int ACC_W    = 32;
	localparam int FF_W     = 48;
	localparam int FB_W     = 32;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 48;
	localparam int Q_SHIFT  = 15;

	localparam logic [CFG_IDX_W-1:0] REG_ACTIVE  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SEC0_FF = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SEC0_FB = 3'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_MAC,
		ST_WAIT,
		ST_WB,
		ST_DONE
	} seq_state_t;

	typedef enum logic [2:0] {
		STEP_A0,
		STEP_A1,
		STEP_A2,
		STEP_B1,
		STEP_B2
	} mac_step_t;

	typedef struct packed {
		logic valid;
		logic clear;
		logic dbl;
		logic neg;
	} mac_ctrl_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] y2;
		logic signed [SAMPLE_W-1:0] y1;
		logic signed [SAMPLE_W-1:0] x2;
		logic signed [SAMPLE_W-1:0] x1;
	} delay_t;

endpackage

FILE: design/cbiq_state_ram.sv
// ----------------------------------------------------------------------------
// cbiq_state_ram
// Delay-line store, one word per section: one write port, one read port,
// read data registered.
// ----------------------------------------------------------------------------
module cbiq_state_ram #(
	parameter int DEPTH = 3,
	parameter int AW    = 2
) (
	input  logic            clk,
	input  logic            we,
	input  logic [AW-1:0]   waddr,
	input  cbiq_pkg::delay_t wdata,
	input  logic            re,
	input  logic [AW-1:0]   raddr,
	output cbiq_pkg::delay_t rdata
);

	cbiq_pkg::delay_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: design/cbiq_mac.sv
// ----------------------------------------------------------------------------
// cbiq_mac
// Shared 16x16 multiply-accumulate: registered product, then a 32-bit
// wrapping accumulate with optional doubling and subtraction.
// ----------------------------------------------------------------------------
module cbiq_mac (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  cbiq_pkg::mac_ctrl_t                   ctrl,
	input  logic signed [cbiq_pkg::SAMPLE_W-1:0]  a,
	input  logic signed [cbiq_pkg::SAMPLE_W-1:0]  b,
	output logic signed [cbiq_pkg::ACC_W-1:0]     acc
);

	cbiq_pkg::mac_ctrl_t                  ctrl_s1;
	logic signed [cbiq_pkg::ACC_W-1:0]    prod_s1;
	logic signed [cbiq_pkg::ACC_W-1:0]    acc_s2;
	logic signed [cbiq_pkg::ACC_W-1:0]    term;
	logic signed [cbiq_pkg::ACC_W-1:0]    base;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s1 <= '0;
		end else begin
			ctrl_s1 <= ctrl;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= a * b;
	end

	always_comb begin
		term = ctrl_s1.dbl ? {prod_s1[cbiq_pkg::ACC_W-2:0], 1'b0} : prod_s1;
		base = ctrl_s1.clear ? '0 : acc_s2;
	end

	always_ff @(posedge clk) begin
		if (ctrl_s1.valid) begin
			acc_s2 <= ctrl_s1.neg ? base - term : base + term;
		end
	end

	assign acc = acc_s2;

endmodule

FILE: design/cascaded_biquad_iir_q15_core.sv
// ----------------------------------------------------------------------------
// cascaded_biquad_iir_q15_core
// One to three cascaded Direct Form I biquads in Q15 on one shared MAC,
// with per-section delay lines held in a synchronous state RAM.
// ----------------------------------------------------------------------------
// Each section steps through state RAM read, five MAC issues through the
// two-stage MAC, drain and write-back. A new input beat is taken only once
// the previous sample has left the last section for the output register.
// The output register holds a finished beat while the next one is taken.
// Reset: asynchronous, clears control, coefficients and section valid bits;
// unwritten delay words read as zero. active_sections resets to 1.
// ----------------------------------------------------------------------------
module cascaded_biquad_iir_q15_core #(
	parameter int MAX_SECTIONS = 3
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	input  logic [15:0]                          s_tdata,   // sample_in [15:0]
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	output logic [15:0]                          m_tdata,   // sample_out [15:0]
	input  logic                                 cfg_we,
	input  logic [cbiq_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [cbiq_pkg::CFG_DATA_W-1:0]      cfg_data
);

	localparam int AW = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;

	cbiq_pkg::seq_state_t state_q, state_d;
	cbiq_pkg::mac_step_t  step_q, step_d;
	cbiq_pkg::mac_ctrl_t  mac_ctrl;
	cbiq_pkg::delay_t     rd_data, wr_data, dl_q;

	logic [1:0]                           act_q;
	logic [cbiq_pkg::FF_W-1:0]            ff_q [MAX_SECTIONS];
	logic [cbiq_pkg::FB_W-1:0]            fb_q [MAX_SECTIONS];
	logic [MAX_SECTIONS-1:0]              valid_q;
	logic [AW-1:0]                        sec_q;
	logic [AW-1:0]                        last_sec;
	logic [1:0]                           last2;
	logic [AW-1:0]                        rd_addr;
	logic                                 rd_en, wr_en, load_out;
	logic signed [cbiq_pkg::SAMPLE_W-1:0] cur_q, y, mac_a, mac_b;
	logic signed [cbiq_pkg::ACC_W-1:0]    acc;
	logic                                 m_tvalid_q;
	logic [15:0]                          m_tdata_q;
	logic [cbiq_pkg::FF_W-1:0]            ff_sel;
	logic [cbiq_pkg::FB_W-1:0]            fb_sel;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q <= 2'd1;
			for (int s = 0; s < MAX_SECTIONS; s++) begin
				ff_q[s] <= '0;
				fb_q[s] <= '0;
			end
		end else if (cfg_we) begin
			if (cfg_index == cbiq_pkg::REG_ACTIVE) begin
				act_q <= cfg_data[1:0];
			end
			for (int s = 0; s < MAX_SECTIONS; s++) begin
				if (cfg_index == 3'(cbiq_pkg::REG_SEC0_FF + 2 * s)) begin
					ff_q[s] <= cfg_data[cbiq_pkg::FF_W-1:0];
				end
				if (cfg_index == 3'(cbiq_pkg::REG_SEC0_FB + 2 * s)) begin
					fb_q[s] <= cfg_data[cbiq_pkg::FB_W-1:0];
				end
			end
		end
	end

	always_comb begin
		if (act_q == 2'd0) begin
			last2 = 2'd0;
		end else if (32'(act_q) > MAX_SECTIONS) begin
			last2 = 2'(MAX_SECTIONS - 1);
		end else begin
			last2 = act_q - 2'd1;
		end
	end

	assign last_sec = last2[AW-1:0];
	assign ff_sel   = ff_q[sec_q];
	assign fb_sel   = fb_q[sec_q];
	assign y        = acc[cbiq_pkg::Q_SHIFT+15:cbiq_pkg::Q_SHIFT];
	assign wr_data  = '{y2: dl_q.y1, y1: y, x2: dl_q.x1, x1: cur_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cbiq_pkg::ST_IDLE;
			step_q  <= cbiq_pkg::STEP_A0;
		end else begin
			state_q <= state_d;
			step_q  <= step_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		step_d   = step_q;
		s_tready = 1'b0;
		rd_en    = 1'b0;
		rd_addr  = sec_q + AW'(1);
		wr_en    = 1'b0;
		load_out = 1'b0;
		mac_ctrl = '0;
		mac_a    = '0;
		mac_b    = '0;
		case (state_q)
			cbiq_pkg::ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					rd_en   = 1'b1;
					rd_addr = '0;
					state_d = cbiq_pkg::ST_LOAD;
				end
			end
			cbiq_pkg::ST_LOAD: begin
				step_d  = cbiq_pkg::STEP_A0;
				state_d = cbiq_pkg::ST_MAC;
			end
			cbiq_pkg::ST_MAC: begin
				mac_ctrl.valid = 1'b1;
				case (step_q)
					cbiq_pkg::STEP_A0: begin
						mac_ctrl.clear = 1'b1;
						mac_a  = cur_q;
						mac_b  = ff_sel[15:0];
						step_d = cbiq_pkg::STEP_A1;
					end
					cbiq_pkg::STEP_A1: begin
						mac_ctrl.dbl = 1'b1;
						mac_a  = dl_q.x1;
						mac_b  = ff_sel[31:16];
						step_d = cbiq_pkg::STEP_A2;
					end
					cbiq_pkg::STEP_A2: begin
						mac_a  = dl_q.x2;
						mac_b  = ff_sel[47:32];
						step_d = cbiq_pkg::STEP_B1;
					end
					cbiq_pkg::STEP_B1: begin
						mac_ctrl.dbl = 1'b1;
						mac_ctrl.neg = 1'b1;
						mac_a  = dl_q.y1;
						mac_b  = fb_sel[15:0];
						step_d = cbiq_pkg::STEP_B2;
					end
					cbiq_pkg::STEP_B2: begin
						mac_ctrl.neg = 1'b1;
						mac_a   = dl_q.y2;
						mac_b   = fb_sel[31:16];
						step_d  = cbiq_pkg::STEP_A0;
						state_d = cbiq_pkg::ST_WAIT;
					end
					default: begin
						mac_ctrl = '0;
						step_d   = cbiq_pkg::STEP_A0;
					end
				endcase
			end
			cbiq_pkg::ST_WAIT: begin
				state_d = cbiq_pkg::ST_WB;
			end
			cbiq_pkg::ST_WB: begin
				wr_en = 1'b1;
				if (sec_q == last_sec) begin
					state_d = cbiq_pkg::ST_DONE;
				end else begin
					rd_en   = 1'b1;
					state_d = cbiq_pkg::ST_LOAD;
				end
			end
			cbiq_pkg::ST_DONE: begin
				if (!m_tvalid_q || m_tready) begin
					load_out = 1'b1;
					state_d  = cbiq_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = cbiq_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sec_q   <= '0;
			valid_q <= '0;
		end else begin
			if (state_q == cbiq_pkg::ST_IDLE) begin
				sec_q <= '0;
			end else if (state_q == cbiq_pkg::ST_WB) begin
				valid_q[sec_q] <= 1'b1;
				if (sec_q != last_sec) begin
					sec_q <= sec_q + AW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			cur_q <= s_tdata;
		end else if (wr_en) begin
			cur_q <= y;
		end
		if (state_q == cbiq_pkg::ST_LOAD) begin
			dl_q <= valid_q[sec_q] ? rd_data : '0;
		end
		if (load_out) begin
			m_tdata_q <= cur_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (load_out) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	cbiq_state_ram #(
		.DEPTH (MAX_SECTIONS),
		.AW    (AW)
	) u_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (sec_q),
		.wdata (wr_data),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	cbiq_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (mac_ctrl),
		.a      (mac_a),
		.b      (mac_b),
		.acc    (acc)
	);

endmodule

FILE: design/cbiq_checker.sv
// ----------------------------------------------------------------------------
// cbiq_checker
// Port-level checks for the cascaded biquad core, bound to the top level.
// ----------------------------------------------------------------------------
module cbiq_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [15:0] m_tdata
);

	a_busy_after_beat: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("input beat taken while a sample is in flight");

	a_no_instant_result: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !$rose(m_tvalid))
		else $error("result appeared one cycle after input beat");

	a_idle_until_result: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> ##1 !s_tready)
		else $error("core idle before the first section finished");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
		else $error("stalled output beat changed");

endmodule

bind cascaded_biquad_iir_q15_core cbiq_checker u_cbiq_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
